// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the top-level rtl file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, held off during reset
`define HUD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication, held off during reset
`define HUD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- sv/hud_pkg.sv -----
// ----------------------------------------------------------------------------
// hud_pkg
// Types and constants shared by the H4 packet deframer modules.
// ----------------------------------------------------------------------------
package hud_pkg;

    // input operation codes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // packet kind codes
    localparam logic KIND_EVENT = 1'b0;
    localparam logic KIND_ACL   = 1'b1;

    // H4 packet indicators
    localparam logic [7:0] IND_EVENT = 8'h04;
    localparam logic [7:0] IND_ACL   = 8'h02;

    // ACL header length and the position of the length low byte in it
    localparam logic [2:0] ACL_HDR_BYTES  = 3'd4;
    localparam logic [2:0] ACL_HDR_LEN_LO = 3'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_EVENTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIVER_ACL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACL_LIMIT      = 2'd2;

    localparam logic [15:0] ACL_LIMIT_RESET = 16'd1020;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_kind;
        logic       last_of_packet;
        logic       dropped;
    } out_item_t;

    typedef struct packed {
        logic        deliver_events;
        logic        deliver_acl;
        logic [15:0] acl_payload_limit;
    } cfg_t;

endpackage

// ----- sv/hud_parser.sv -----
// ----------------------------------------------------------------------------
// hud_parser
// H4 framing state machine: updates the parse state on each accepted item
// and forms the result byte for the output queue.
// ----------------------------------------------------------------------------
module hud_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  hud_pkg::in_item_t  item,
    input  hud_pkg::cfg_t      cfg,
    output logic               res_valid,
    output hud_pkg::out_item_t res
);
    import hud_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_EVT_CODE  = 3'd1,
        PH_EVT_LEN   = 3'd2,
        PH_EVT_PARAM = 3'd3,
        PH_ACL_HDR   = 3'd4,
        PH_ACL_DATA  = 3'd5
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] remain_reg, remain_next;
    logic [2:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  len_lo_reg, len_lo_next;

    logic [2:0]  hdr_inc;
    logic [15:0] remain_dec;
    logic [15:0] acl_len;
    logic        emit;
    logic        kind;
    logic        last;
    logic        drop;

    // next state and result fields
    always_comb begin
        phase_next   = phase_reg;
        remain_next  = remain_reg;
        hdr_cnt_next = hdr_cnt_reg;
        len_lo_next  = len_lo_reg;
        emit         = 1'b0;
        kind         = KIND_EVENT;
        last         = 1'b0;
        drop         = 1'b0;
        hdr_inc      = hdr_cnt_reg + 3'd1;
        remain_dec   = remain_reg - 16'd1;
        acl_len      = {item.rx_byte, len_lo_reg};

        if (item_valid) begin
            if (item.operation == OP_RESTART) begin
                phase_next   = PH_IDLE;
                remain_next  = '0;
                hdr_cnt_next = '0;
            end else begin
                unique case (phase_reg)
                    PH_EVT_CODE: begin
                        emit       = 1'b1;
                        phase_next = PH_EVT_LEN;
                    end
                    PH_EVT_LEN: begin
                        emit = 1'b1;
                        if (item.rx_byte == 8'd0) begin
                            last        = 1'b1;
                            phase_next  = PH_IDLE;
                            remain_next = '0;
                        end else begin
                            remain_next = {8'd0, item.rx_byte};
                            phase_next  = PH_EVT_PARAM;
                        end
                    end
                    PH_EVT_PARAM: begin
                        emit        = 1'b1;
                        remain_next = remain_dec;
                        if (remain_dec == 16'd0) begin
                            last       = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_ACL_HDR: begin
                        emit         = 1'b1;
                        kind         = KIND_ACL;
                        hdr_cnt_next = hdr_inc;
                        if (hdr_inc == ACL_HDR_LEN_LO) begin
                            len_lo_next = item.rx_byte;
                        end else if (hdr_inc >= ACL_HDR_BYTES) begin
                            // last header byte: length is complete
                            hdr_cnt_next = '0;
                            if (acl_len == 16'd0) begin
                                last        = 1'b1;
                                phase_next  = PH_IDLE;
                                remain_next = '0;
                            end else if (acl_len > cfg.acl_payload_limit) begin
                                last        = 1'b1;
                                drop        = 1'b1;
                                phase_next  = PH_IDLE;
                                remain_next = '0;
                            end else begin
                                remain_next = acl_len;
                                phase_next  = PH_ACL_DATA;
                            end
                        end
                    end
                    PH_ACL_DATA: begin
                        emit        = 1'b1;
                        kind        = KIND_ACL;
                        remain_next = remain_dec;
                        if (remain_dec == 16'd0) begin
                            last       = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    default: begin
                        // idle: hunt for an indicator byte
                        if (item.rx_byte == IND_EVENT) begin
                            phase_next  = PH_EVT_CODE;
                            remain_next = '0;
                        end else if (item.rx_byte == IND_ACL) begin
                            phase_next   = PH_ACL_HDR;
                            hdr_cnt_next = '0;
                            remain_next  = '0;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    // result goes out only when its kind is enabled
    assign res_valid = emit & ((kind == KIND_ACL) ? cfg.deliver_acl : cfg.deliver_events);
    assign res.out_byte       = item.rx_byte;
    assign res.packet_kind    = kind;
    assign res.last_of_packet = last;
    assign res.dropped        = drop;

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            remain_reg  <= '0;
            hdr_cnt_reg <= '0;
            len_lo_reg  <= '0;
        end else begin
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            hdr_cnt_reg <= hdr_cnt_next;
            len_lo_reg  <= len_lo_next;
        end
    end

endmodule

// ----- sv/hud_outq.sv -----
// ----------------------------------------------------------------------------
// hud_outq
// Two-entry result queue: holds finished bytes so the input side keeps
// flowing while the result side stalls, until both entries are full.
// ----------------------------------------------------------------------------
module hud_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  hud_pkg::out_item_t push_data,
    output logic               not_full,
    output logic               m_valid,
    input  logic               m_ready,
    output hud_pkg::out_item_t m_data
);
    import hud_pkg::*;

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop      = m_valid & m_ready;
    assign m_valid  = (count_reg != 2'd0);
    assign not_full = (count_reg != 2'd2);
    assign m_data   = slot_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/hci_uart_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// hci_uart_packet_deframer
// Frames received UART bytes into HCI H4 event and ACL packets and streams
// every packet byte out with its kind, an end-of-packet flag and a drop flag.
// ----------------------------------------------------------------------------
// Takes one item per clock while s_ready is high. A result is registered in
// the result queue before it shows on the m_ channel; the parse state is a
// single register stage, so each byte is framed in the cycle it is accepted.
// A two-entry result queue decouples the sides: input keeps flowing while
// one result waits, and s_ready drops only when both queue entries hold
// untaken results. Indicator bytes, bytes of a disabled kind and restart
// items produce no result. Configuration writes are always accepted
// (cfg_ready is high) and should be issued only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hci_uart_packet_deframer (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  hud_pkg::in_item_t                     s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output hud_pkg::out_item_t                    m_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [hud_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [15:0]                           cfg_data
);
    import hud_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      item_acc;
    logic      res_valid;
    out_item_t res;

    assign cfg_ready = 1'b1;
    assign item_acc  = s_valid & s_ready;

    // configuration register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DELIVER_EVENTS: cfg_next.deliver_events    = cfg_data[0];
                CFG_DELIVER_ACL:    cfg_next.deliver_acl       = cfg_data[0];
                CFG_ACL_LIMIT:      cfg_next.acl_payload_limit = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.deliver_events    <= 1'b0;
            cfg_reg.deliver_acl       <= 1'b0;
            cfg_reg.acl_payload_limit <= ACL_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // framing state machine
    hud_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_acc),
        .item       (s_data),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result queue
    hud_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (item_acc & res_valid),
        .push_data (res),
        .not_full  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a restart never yields a result
    `HUD_ASSERT_IMPLY(a_restart_silent, item_acc && s_data.operation == OP_RESTART, !res_valid, "restart produced a result")

    // a dropped byte always ends an ACL packet
    `HUD_ASSERT_IMPLY(a_drop_is_acl_end, m_valid && m_data.dropped, m_data.last_of_packet && m_data.packet_kind == KIND_ACL, "drop flag on a non-final or event byte")

    // input stalls only behind queued results
    `HUD_ASSERT_IMPLY(a_stall_has_output, !s_ready, m_valid, "input stalled with empty queue")

endmodule

// ----- dv/hud_frame_checker.sv -----
// ----------------------------------------------------------------------------
// hud_frame_checker
// Watches the byte, result and register channels of the H4 packet deframer,
// frames every accepted byte in its own copy of the parser and compares each
// result transfer, field by field, with the oldest framed byte still due.
// ----------------------------------------------------------------------------
module hud_frame_checker
    import hud_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output int unsigned          fail_count,
    output int unsigned          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_EVT_CODE,
        FR_EVT_LEN,
        FR_EVT_PARAM,
        FR_ACL_HDR,
        FR_ACL_DATA
    } frame_phase_e;

    // parser copy and register copy
    frame_phase_e phase;
    logic [15:0]  remaining;
    logic [2:0]   hdr_seen;
    logic [7:0]   len_lo;
    cfg_t         regs;

    out_item_t    due_bytes[$];
    int unsigned  errors;

    // frames one input transfer, returns 1 when it yields a result
    function automatic bit frame_step(input in_item_t item, output out_item_t res);
        logic        en;
        logic [15:0] hdr_len;
        res = '0;
        if (item.operation == OP_RESTART) begin
            phase = FR_IDLE;
            remaining = '0;
            hdr_seen = '0;
            return 1'b0;
        end
        res.out_byte = item.rx_byte;
        res.packet_kind = KIND_EVENT;
        en = regs.deliver_events;
        case (phase)
            FR_EVT_CODE: begin
                phase = FR_EVT_LEN;
            end
            FR_EVT_LEN: begin
                if (item.rx_byte == 8'd0) begin
                    phase = FR_IDLE;
                    remaining = '0;
                    res.last_of_packet = 1'b1;
                end else begin
                    remaining = {8'd0, item.rx_byte};
                    phase = FR_EVT_PARAM;
                end
            end
            FR_EVT_PARAM: begin
                remaining = remaining - 16'd1;
                if (remaining == 16'd0) begin
                    phase = FR_IDLE;
                    res.last_of_packet = 1'b1;
                end
            end
            FR_ACL_HDR: begin
                en = regs.deliver_acl;
                res.packet_kind = KIND_ACL;
                hdr_seen = hdr_seen + 3'd1;
                if (hdr_seen == ACL_HDR_LEN_LO) begin
                    len_lo = item.rx_byte;
                end else if (hdr_seen == ACL_HDR_BYTES) begin
                    hdr_seen = '0;
                    hdr_len = {item.rx_byte, len_lo};
                    if (hdr_len == 16'd0) begin
                        phase = FR_IDLE;
                        remaining = '0;
                        res.last_of_packet = 1'b1;
                    end else if (hdr_len > regs.acl_payload_limit) begin
                        // oversized payload: abort on the last header byte
                        phase = FR_IDLE;
                        remaining = '0;
                        res.last_of_packet = 1'b1;
                        res.dropped = 1'b1;
                    end else begin
                        remaining = hdr_len;
                        phase = FR_ACL_DATA;
                    end
                end
            end
            FR_ACL_DATA: begin
                en = regs.deliver_acl;
                res.packet_kind = KIND_ACL;
                remaining = remaining - 16'd1;
                if (remaining == 16'd0) begin
                    phase = FR_IDLE;
                    res.last_of_packet = 1'b1;
                end
            end
            default: begin
                // idle: only an indicator starts a packet
                if (item.rx_byte == IND_EVENT) begin
                    phase = FR_EVT_CODE;
                    remaining = '0;
                end else if (item.rx_byte == IND_ACL) begin
                    phase = FR_ACL_HDR;
                    hdr_seen = '0;
                    remaining = '0;
                end
                return 1'b0;
            end
        endcase
        return en;
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t ns: %s", $realtime, msg);
    endtask

    // watch all three channels at each edge
    always @(posedge aclk) begin
        out_item_t due;
        out_item_t framed;
        if (!aresetn) begin
            due_bytes.delete();
            phase = FR_IDLE;
            remaining = '0;
            hdr_seen = '0;
            len_lo = '0;
            regs = '{deliver_events: 1'b0, deliver_acl: 1'b0,
                     acl_payload_limit: ACL_LIMIT_RESET};
        end else begin
            // result transfer against the oldest byte due
            if (m_valid && m_ready) begin
                if (due_bytes.size() == 0) begin
                    note_failure($sformatf("unexpected result: byte %02h kind %0d last %0d drop %0d",
                        m_data.out_byte, m_data.packet_kind, m_data.last_of_packet,
                        m_data.dropped));
                end else begin
                    due = due_bytes.pop_front();
                    if (m_data.out_byte !== due.out_byte ||
                        m_data.packet_kind !== due.packet_kind ||
                        m_data.last_of_packet !== due.last_of_packet ||
                        m_data.dropped !== due.dropped)
                        note_failure($sformatf(
                            "mismatch: expected byte %02h kind %0d last %0d drop %0d, got byte %02h kind %0d last %0d drop %0d",
                            due.out_byte, due.packet_kind, due.last_of_packet, due.dropped,
                            m_data.out_byte, m_data.packet_kind, m_data.last_of_packet,
                            m_data.dropped));
                end
            end
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DELIVER_EVENTS: regs.deliver_events = cfg_data[0];
                    CFG_DELIVER_ACL:    regs.deliver_acl = cfg_data[0];
                    CFG_ACL_LIMIT:      regs.acl_payload_limit = cfg_data;
                    default: ;
                endcase
            end
            // input transfer
            if (s_valid && s_ready) begin
                if (frame_step(s_data, framed))
                    due_bytes.push_back(framed);
            end
        end
        pending <= due_bytes.size();
        fail_count <= errors;
    end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives the H4 packet deframer with random event and ACL packets, noise and
// cut-off packets under several register settings, with a short directed
// sequence after the first run and random idling on both channels. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hud_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b1;
    out_item_t            m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data = '0;

    int unsigned fail_count;
    int unsigned pending;

    // idling controls
    bit          quiet = 1'b0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned sink_hold = 0;

    int unsigned packet_bytes;
    logic [15:0] cur_limit = ACL_LIMIT_RESET;

    hci_uart_packet_deframer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hud_frame_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #5 aclk = ~aclk;

    // result side: ready stretches broken by stall bursts
    always @(posedge aclk) begin
        if (quiet) begin
            m_ready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if (m_ready && $urandom_range(99) < stall_pct) begin
            m_ready <= 1'b0;
            sink_hold <= $urandom_range(0, 17);
        end else begin
            m_ready <= 1'b1;
            sink_hold <= $urandom_range(0, 12);
        end
    end

    // one input transfer, with an optional idle burst ahead of it
    task automatic put_item(input logic op, input logic [7:0] b);
        int unsigned gap;
        if (!quiet && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{operation: op, rx_byte: b};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic put_byte(input logic [7:0] b);
        put_item(OP_BYTE, b);
        packet_bytes++;
    endtask

    // wait for every result, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input logic ev, input logic acl, input logic [15:0] lim);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [15:0]          val [3];
        idx = '{CFG_DELIVER_EVENTS, CFG_DELIVER_ACL, CFG_ACL_LIMIT};
        val = '{{15'd0, ev}, {15'd0, acl}, lim};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        cur_limit = lim;
    endtask

    // one random packet, noise byte or restart; packets may be cut by a restart
    task automatic send_packet();
        logic [7:0]  pkt[$];
        logic [7:0]  b;
        logic [15:0] len;
        int unsigned pick, n, avail, cut;
        bit          forced;
        forced = 1'b0;
        if ($urandom_range(99) < 5) begin
            gap_pct <= ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 10 : 35);
            stall_pct <= ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 10 : 35);
        end
        pick = $urandom_range(99);
        if (pick < 44) begin
            // event packet
            n = ($urandom_range(49) == 0) ? 255 : $urandom_range(0, 12);
            pkt = '{IND_EVENT, 8'($urandom_range(255)), 8'(n)};
            for (int i = 0; i < n; i++)
                pkt.push_back(8'($urandom_range(255)));
        end else if (pick < 88) begin
            // acl packet
            pick = $urandom_range(99);
            if (pick < 50)
                len = 16'($urandom_range(0, 12));
            else if (pick < 60)
                len = cur_limit;
            else if (pick < 68)
                len = cur_limit + 16'd1;
            else if (pick < 75)
                len = 16'd0;
            else
                len = 16'($urandom_range(0, 65535));
            pkt = '{IND_ACL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    len[7:0], len[15:8]};
            avail = (len > cur_limit) ? 0 : len;
            // long payloads are cut short by a restart
            if (avail > 300) begin
                avail = $urandom_range(1, 40);
                forced = 1'b1;
            end
            for (int i = 0; i < avail; i++)
                pkt.push_back(8'($urandom_range(255)));
        end else if (pick < 94) begin
            // noise while idle
            do b = 8'($urandom_range(255)); while (b == IND_EVENT || b == IND_ACL);
            put_item(OP_BYTE, b);
            return;
        end else begin
            put_item(OP_RESTART, 8'($urandom_range(255)));
            return;
        end
        if (forced || $urandom_range(99) >= 8)
            cut = pkt.size();
        else
            cut = $urandom_range(1, pkt.size() - 1);
        for (int i = 0; i < cut; i++)
            put_byte(pkt[i]);
        if (forced || cut < pkt.size())
            put_item(OP_RESTART, 8'($urandom_range(255)));
    endtask

    task automatic run_phase(input logic ev, input logic acl, input logic [15:0] lim,
                             input int unsigned n);
        settle();
        program_regs(ev, acl, lim);
        packet_bytes = 0;
        while (packet_bytes < n) send_packet();
    endtask

    // stimulus and verdict
    initial begin
        logic [7:0] opening [];
        opening = '{8'hFF,
                    IND_EVENT, 8'hFF, 8'h00,
                    IND_EVENT, 8'h0E, 8'h01, 8'h55,
                    IND_ACL, 8'hFF, 8'hFF, 8'h00, 8'h00,
                    IND_ACL, 8'h01, 8'h20, 8'h09, 8'h00,
                    IND_ACL, 8'h00, 8'h00, 8'h01, 8'h00, 8'h80,
                    IND_EVENT};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: both kinds parsed silently
        gap_pct <= 10;
        stall_pct <= 10;
        packet_bytes = 0;
        while (packet_bytes < 60) send_packet();

        // directed: noise, zero lengths, oversized acl, short packets, restart mid-event
        settle();
        program_regs(1'b1, 1'b1, 16'd8);
        foreach (opening[i])
            put_item(OP_BYTE, opening[i]);
        put_item(OP_RESTART, 8'hFF);

        run_phase(1'b1, 1'b1, 16'd1020, 100);
        run_phase(1'b1, 1'b1, 16'd0, 220);
        run_phase(1'b1, 1'b0, 16'hFFFF, 250);
        run_phase(1'b0, 1'b1, 16'd16, 220);
        run_phase(1'b1, 1'b1, 16'hFFFF, 250);
        run_phase(1'b0, 1'b0, 16'd3, 120);
        run_phase(1'b1, 1'b1, 16'd3, 200);
        // closing stretch runs without idling
        quiet <= 1'b1;
        run_phase(1'b1, 1'b1, 16'd1020, 250);

        settle();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- hci_uart_packet_deframer.f -----
+incdir+sv
sv/hud_pkg.sv
sv/hud_parser.sv
sv/hud_outq.sv
sv/hci_uart_packet_deframer.sv
dv/hud_frame_checker.sv
dv/tb.sv
